// File: sv/rrss_pkg.sv
package rrss_pkg;

   // one queued job: id and remaining time
   typedef struct packed {
      logic [15:0] id;
      logic [15:0] left;
   } job_type;

   // per-cell control: load a new job or take the neighbor's job
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   // result status codes
   localparam logic [2:0] ST_ADDED  = 3'd0;
   localparam logic [2:0] ST_FULL   = 3'd1;
   localparam logic [2:0] ST_SLICED = 3'd2;
   localparam logic [2:0] ST_DONE   = 3'd3;
   localparam logic [2:0] ST_EMPTY  = 3'd4;

   // op codes
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_RUN = 1'b1;

   localparam logic [15:0] QUANTUM_RESET = 16'd4;

   // fixed part of the result word: slice_job, time_used, time_left, total_used
   localparam int RSP_FIXED_W = 80;

endpackage

// File: sv/rrss_cell.sv
module rrss_cell (
   input  logic                  clock,
   input  rrss_pkg::cell_ctl_type ctl,
   input  rrss_pkg::job_type     next_job,
   input  rrss_pkg::job_type     load_job,
   output rrss_pkg::job_type     job
);
   import rrss_pkg::*;

   job_type job_ff;
   job_type job_in;

   // a load wins over the shift from the neighbor
   always_comb begin
      job_in = job_ff;
      if (ctl.load) begin
         job_in = load_job;
      end else if (ctl.shift) begin
         job_in = next_job;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job = job_ff;

endmodule

// File: sv/round_robin_slice_scheduler_unit.sv
// round-robin time-slice scheduler
// req channel: one word per step; req_tuser[0] is the op (0 add a job, 1 run
//   one slice), req_tdata carries job_id and burst_time (used by add only)
// rsp channel: exactly one word per req word, in order; rsp_tuser carries the
//   status (added, rejected full, sliced and requeued, completed, empty) and
//   rsp_tdata the slice job, time used, time left, total used, jobs waiting
// csr port: csr_we writes csr_wdata into the quantum register (reset 4, a
//   quantum of zero acts as one); write only while no word is in flight
// the ready queue is a row of QUEUE_DEPTH cells, cell 0 holding the head job;
//   a run shifts every cell one place toward the head and a requeued job is
//   loaded into the cell just behind the last occupied one
// steps: a word is taken in S_IDLE into the request register in front of
//   the cell row and executed in S_EXEC once the rsp register is free; the
//   execute step loads the result word into the rsp register that drives rsp
// a new req word is taken while an earlier result still waits on rsp; the
//   execute step then holds until the rsp register is free, so a stalled
//   receiver stalls the req side after one more word
// reset empties the queue count, clears the total time and sets the quantum
//   back to 4; the job cells themselves are not cleared
module round_robin_slice_scheduler_unit #(
   parameter int QUEUE_DEPTH = 64,
   localparam int CW = $clog2(QUEUE_DEPTH + 1),
   localparam int RSP_W = ((rrss_pkg::RSP_FIXED_W + CW + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // req
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,   // job_id [15:0], burst_time [31:16]
   input  logic [0:0]       req_tuser,   // op [0]
   // rsp
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // slice_job, time_used, time_left,
                                         // total_used, jobs_waiting, zero pad
   output logic [2:0]       rsp_tuser,   // status [2:0]
   // csr
   input  logic             csr_we,
   input  logic [15:0]      csr_wdata    // quantum
);
   import rrss_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;

   // captured request
   logic        op_ff;
   logic [15:0] id_ff;
   logic [15:0] burst_ff;

   logic [15:0]   quantum_ff;
   logic [CW-1:0] occ_ff, occ_in;
   logic [31:0]   total_ff, total_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;

   // cell row
   job_type      cell_job [QUEUE_DEPTH];
   cell_ctl_type cell_ctl [QUEUE_DEPTH];
   job_type      load_job;
   logic [AW-1:0] load_pos;
   logic          do_load;
   logic          do_shift;

   // execute-step datapath
   logic        exec_go;
   logic        is_full;
   logic        is_empty;
   logic [15:0] q_eff;
   logic [15:0] used;
   logic [15:0] left;
   logic [15:0] sjob;
   logic [2:0]  status;
   logic [32:0] sum;

   assign req_tready = (state_ff == S_IDLE);
   assign exec_go    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   assign is_full  = (occ_ff == CW'(QUEUE_DEPTH));
   assign is_empty = (occ_ff == '0);
   assign q_eff    = (quantum_ff == 16'd0) ? 16'd1 : quantum_ff;

   always_comb begin
      do_load  = 1'b0;
      do_shift = 1'b0;
      load_pos = occ_ff[AW-1:0];
      load_job = '{id: id_ff, left: burst_ff};
      occ_in   = occ_ff;
      sjob     = 16'd0;
      used     = 16'd0;
      left     = 16'd0;
      status   = ST_EMPTY;
      if (op_ff == OP_ADD) begin
         if (is_full) begin
            status = ST_FULL;
         end else begin
            status  = ST_ADDED;
            do_load = exec_go;
            occ_in  = occ_ff + CW'(1);
         end
      end else if (!is_empty) begin
         do_shift = exec_go;
         sjob     = cell_job[0].id;
         if (cell_job[0].left > q_eff) begin
            // slice and requeue behind the last job left after the shift
            status   = ST_SLICED;
            used     = q_eff;
            left     = cell_job[0].left - q_eff;
            do_load  = exec_go;
            load_pos = AW'(occ_ff - CW'(1));
            load_job = '{id: cell_job[0].id, left: left};
         end else begin
            status = ST_DONE;
            used   = cell_job[0].left;
            occ_in = occ_ff - CW'(1);
         end
      end
   end

   // saturating running total
   assign sum      = {1'b0, total_ff} + {17'd0, used};
   assign total_in = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[15:0]  = sjob;
      rsp_data_in[31:16] = used;
      rsp_data_in[47:32] = left;
      rsp_data_in[79:48] = total_in;
      rsp_data_in[RSP_FIXED_W +: CW] = occ_in;
      rsp_status_in = status;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
         total_ff     <= '0;
         quantum_ff   <= QUANTUM_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            quantum_ff <= csr_wdata;
         end
         if (exec_go) begin
            occ_ff        <= occ_in;
            total_ff      <= total_in;
            rsp_data_ff   <= rsp_data_in;
            rsp_status_ff <= rsp_status_in;
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff    <= req_tuser[0];
         id_ff    <= req_tdata[15:0];
         burst_ff <= req_tdata[31:16];
      end
   end

   // cell row: cell i takes cell i+1 on a shift; the last cell has no neighbor and takes load_job
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      job_type next_job;

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_job = load_job;
      end else begin : g_mid
         assign next_job = cell_job[i + 1];
      end

      assign cell_ctl[i] = '{load: do_load && (load_pos == AW'(i)), shift: do_shift};

      rrss_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[i]),
         .next_job (next_job),
         .load_job (load_job),
         .job      (cell_job[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: tb/rrss_checker.sv
`timescale 1ns / 1ps

// watches both channels and the csr port, predicts each result word and
// compares it against the oldest prediction still waiting
module rrss_checker #(
   parameter int QUEUE_DEPTH = 64,
   parameter int RSP_W = 88
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [31:0]      req_tdata,   // job_id [15:0], burst_time [31:16]
   input  logic [0:0]       req_tuser,   // op [0]
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,   // slice_job, time_used, time_left,
                                         // total_used, jobs_waiting, zero pad
   input  logic [2:0]       rsp_tuser,   // status [2:0]
   input  logic             csr_we,
   input  logic [15:0]      csr_wdata,
   output int               pending_slices,
   output int               mismatches
);
   import rrss_pkg::*;

   localparam int JOB_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [2:0]             status;
      logic [15:0]            slice_job;
      logic [15:0]            time_used;
      logic [15:0]            time_left;
      logic [31:0]            total_used;
      logic [JOB_COUNT_W-1:0] jobs_waiting;
   } slice_result_type;

   // private copy of the scheduler state
   job_type     ready_ring [QUEUE_DEPTH];
   int unsigned ring_head;
   int unsigned ring_tail;
   int unsigned jobs_queued;
   logic [31:0] used_total;
   logic [15:0] quantum_reg;

   slice_result_type expected_slices[$];
   int unsigned      result_index;

   task automatic report_mismatch(input string what);
      $display("[%0t] result %0d: %s", $realtime, result_index, what);
      mismatches++;
   endtask

   function automatic void enqueue_job(input job_type job);
      ready_ring[ring_tail] = job;
      ring_tail = (ring_tail + 1) % QUEUE_DEPTH;
      jobs_queued++;
   endfunction

   function automatic slice_result_type schedule_step(input logic op,
                                                      input logic [15:0] job_id,
                                                      input logic [15:0] burst_time);
      slice_result_type r;
      job_type          head_job;
      logic [15:0]      slice_len;
      logic [32:0]      sum;
      r = '0;
      if (op == OP_ADD) begin
         if (jobs_queued >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            enqueue_job('{id: job_id, left: burst_time});
            r.status = ST_ADDED;
         end
      end else if (jobs_queued == 0) begin
         r.status = ST_EMPTY;
      end else begin
         head_job  = ready_ring[ring_head];
         ring_head = (ring_head + 1) % QUEUE_DEPTH;
         jobs_queued--;
         // a zero quantum still grants one unit
         slice_len   = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;
         r.slice_job = head_job.id;
         if (head_job.left > slice_len) begin
            r.time_used = slice_len;
            r.time_left = head_job.left - slice_len;
            enqueue_job('{id: head_job.id, left: r.time_left});
            r.status = ST_SLICED;
         end else begin
            r.time_used = head_job.left;
            r.status    = ST_DONE;
         end
         sum = {1'b0, used_total} + {17'd0, r.time_used};
         used_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
      r.total_used   = used_total;
      r.jobs_waiting = jobs_queued[JOB_COUNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      slice_result_type want;
      slice_result_type got;
      if (reset) begin
         ring_head   = 0;
         ring_tail   = 0;
         jobs_queued = 0;
         used_total  = '0;
         quantum_reg = QUANTUM_RESET;
         expected_slices.delete();
      end else begin
         if (csr_we)
            quantum_reg = csr_wdata;
         // a result word is always older than a req word taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.status       = rsp_tuser;
            got.slice_job    = rsp_tdata[15:0];
            got.time_used    = rsp_tdata[31:16];
            got.time_left    = rsp_tdata[47:32];
            got.total_used   = rsp_tdata[79:48];
            got.jobs_waiting = rsp_tdata[80 +: JOB_COUNT_W];
            if (expected_slices.size() == 0) begin
               report_mismatch($sformatf("result word with nothing expected, status %0d",
                                         got.status));
            end else begin
               want = expected_slices.pop_front();
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            got.status, want.status));
               if (got.slice_job !== want.slice_job)
                  report_mismatch($sformatf("slice_job %0h, expected %0h",
                                            got.slice_job, want.slice_job));
               if (got.time_used !== want.time_used)
                  report_mismatch($sformatf("time_used %0h, expected %0h",
                                            got.time_used, want.time_used));
               if (got.time_left !== want.time_left)
                  report_mismatch($sformatf("time_left %0h, expected %0h",
                                            got.time_left, want.time_left));
               if (got.total_used !== want.total_used)
                  report_mismatch($sformatf("total_used %0h, expected %0h",
                                            got.total_used, want.total_used));
               if (got.jobs_waiting !== want.jobs_waiting)
                  report_mismatch($sformatf("jobs_waiting %0d, expected %0d",
                                            got.jobs_waiting, want.jobs_waiting));
            end
            result_index++;
         end
         if (req_tvalid && req_tready)
            expected_slices.push_back(schedule_step(req_tuser[0], req_tdata[15:0],
                                                    req_tdata[31:16]));
      end
      pending_slices <= expected_slices.size();
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

// stimulus and verdict for the round-robin slice scheduler; all checking
// lives in the checker instance beside the block
module testbench;
   import rrss_pkg::*;

   localparam int QUEUE_DEPTH = 64;
   localparam int JOB_COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int RSP_W       = ((RSP_FIXED_W + JOB_COUNT_W + 7) / 8) * 8;

   localparam int DRAIN_CYCLES     = 10;
   // long receiver hold so the job pipeline backs up into req
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT      = 200_000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [31:0]      req_tdata = '0;    // job_id [15:0], burst_time [31:16]
   logic [0:0]       req_tuser = '0;    // op [0]
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // slice_job, time_used, time_left,
                                        // total_used, jobs_waiting, zero pad
   logic [2:0]       rsp_tuser;         // status [2:0]
   logic             csr_we = 1'b0;
   logic [15:0]      csr_wdata = '0;

   int               pending_slices;
   int               mismatches;

   // idle percentages per side, changed between phases
   int unsigned      tx_idle_pct = 0;
   int unsigned      rx_idle_pct = 0;
   // quantum as last written, used to shape burst times
   logic [15:0]      quantum_now = QUANTUM_RESET;
   logic             long_hold_armed = 1'b0;
   logic             long_hold_done  = 1'b0;
   int unsigned      cycle_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   round_robin_slice_scheduler_unit #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   rrss_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .RSP_W      (RSP_W)
   ) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .pending_slices (pending_slices),
      .mismatches     (mismatches)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: random back-pressure, plus one long hold once armed
   initial begin : rsp_drive
      int unsigned hold_count;
      hold_count = 0;
      forever begin
         @(posedge clock);
         if (long_hold_armed && !long_hold_done) begin
            rsp_tready <= 1'b0;
            hold_count++;
            if (hold_count == LONG_HOLD_CYCLES)
               long_hold_done = 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // offer one word and hold it until taken; valid stays high into the
   // next word unless a sender gap is drawn
   task automatic send_word(input logic op, input logic [15:0] job_id,
                            input logic [15:0] burst_time);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {burst_time, job_id};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering and let every outstanding result word come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_slices != 0) @(posedge clock);
   endtask

   // quantum only changes while nothing is in flight
   task automatic write_quantum(input logic [15:0] value);
      wait_idle();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we      <= 1'b0;
      quantum_now  = value;
   endtask

   // burst times mostly a few slices long so jobs both requeue and finish
   function automatic logic [15:0] pick_burst();
      int unsigned slice_len;
      int unsigned span;
      slice_len = (quantum_now == 16'd0) ? 1 : quantum_now;
      span      = 3 * slice_len;
      if (span > 65535)
         span = 65535;
      case ($urandom_range(9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom);
         default: return 16'($urandom_range(span));
      endcase
   endfunction

   // a run of words leaning toward filling, draining or neither
   task automatic random_chunk(input int unsigned words);
      int unsigned add_pct;
      case ($urandom_range(2))
         0:       add_pct = 85;
         1:       add_pct = 15;
         default: add_pct = 50;
      endcase
      repeat (words) begin
         if ($urandom_range(99) < add_pct)
            send_word(OP_ADD, 16'($urandom), pick_burst());
         else
            send_word(OP_RUN, 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset quantum of 4
      send_word(OP_RUN, 16'hFFFF, 16'hFFFF);   // empty queue
      send_word(OP_ADD, 16'h0000, 16'h0000);   // zero burst
      send_word(OP_ADD, 16'hFFFF, 16'hFFFF);   // largest id and burst
      send_word(OP_ADD, 16'h1234, 16'd4);      // burst equal to the quantum
      send_word(OP_ADD, 16'h00FF, 16'd5);      // one past the quantum
      send_word(OP_RUN, 16'($urandom), 16'($urandom));   // completes using 0
      send_word(OP_RUN, 16'($urandom), 16'($urandom));   // sliced, requeued
      send_word(OP_RUN, 16'($urandom), 16'($urandom));   // completes exactly
      send_word(OP_RUN, 16'($urandom), 16'($urandom));   // sliced, 1 left
      write_quantum(16'd0);                    // zero acts as one
      send_word(OP_RUN, 16'($urandom), 16'($urandom));
      send_word(OP_RUN, 16'($urandom), 16'($urandom));
      write_quantum(16'hFFFF);                 // largest quantum
      send_word(OP_RUN, 16'($urandom), 16'($urandom));   // finishes last job
      send_word(OP_RUN, 16'($urandom), 16'($urandom));   // empty again

      // phase one: sender idles a bit, receiver a lot
      write_quantum(16'($urandom_range(8, 1)));
      tx_idle_pct = 37;
      rx_idle_pct = 76;
      repeat (8) random_chunk(25);

      // phase two: the other way round, smallest nonzero quantum
      write_quantum(16'd1);
      tx_idle_pct = 76;
      rx_idle_pct = 37;
      repeat (8) random_chunk(25);

      // phase three: no idling; a long receiver hold stalls the adds, which then
      // push the queue past full so some adds are rejected
      write_quantum(16'($urandom));
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      long_hold_armed <= 1'b1;
      repeat (QUEUE_DEPTH + 6) send_word(OP_ADD, 16'($urandom), pick_burst());
      repeat (5) random_chunk(25);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
